// ===== src/ccp_pkg.sv =====
package ccp_pkg;

  // Name length compared and forwarded, and the depth of the name buffer.
  localparam int unsigned NameLen = 8;
  localparam int unsigned NameDepth = 8;
  localparam logic [63:0] NameMask = {64{1'b1}} >> (64 - 8 * NameLen);

  // Depth of the job queue between the front and the back.
  localparam int unsigned QDepth = 2;

  // Command bytes on the chain.
  localparam logic [7:0] ByteListen   = 8'hCC;
  localparam logic [7:0] ByteUnlisten = 8'hEC;
  localparam logic [7:0] ByteNameList = 8'hCE;
  localparam logic [7:0] ByteTypeList = 8'hF3;
  localparam logic [7:0] ByteService  = 8'h53;
  localparam logic [7:0] ByteAirCal   = 8'h63;

  // Configuration register indexes.
  localparam logic [2:0] CfgChainHead   = 3'd0;
  localparam logic [2:0] CfgBehindMstr  = 3'd1;
  localparam logic [2:0] CfgTestMode    = 3'd2;
  localparam logic [2:0] CfgOwnName     = 3'd3;
  localparam logic [2:0] CfgMasterName  = 3'd4;

  typedef enum logic [3:0] {
    ActEcho     = 4'd0,
    ActTypeList = 4'd1,
    ActNameList = 4'd2,
    ActPacket   = 4'd3,
    ActForward  = 4'd4,
    ActUnlisten = 4'd5,
    ActService  = 4'd6,
    ActAirCal   = 4'd7,
    ActHeld     = 4'd8
  } action_e;

  // Byte-driven part of a job, carried out after the answer and the packet.
  typedef enum logic [2:0] {
    CmdNone,
    CmdUnlisten,
    CmdService,
    CmdAirCal,
    CmdForward,
    CmdNameDump
  } cmd_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       path_free;
    logic       tick;
  } in_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic        is_chain_head;
    logic        behind_master;
    logic        test_mode;
    logic [63:0] own_name;
    logic [63:0] master_name;
  } cfg_t;

  // One classified poll: everything the back needs to emit its results.
  typedef struct packed {
    logic        held;
    logic        ans_vld;
    action_e     ans_act;
    logic        pkt;
    cmd_e        cmd;
    logic [7:0]  cmd_byte;
    logic [63:0] name;
  } job_t;

  // Status of the back sequencer.
  typedef struct packed {
    logic busy;
    logic [3:0] idx;
  } back_stat_t;

endpackage

// ===== src/ccp_front.sv =====
module ccp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ccp_pkg::in_t  item_i,
  input  ccp_pkg::cfg_t cfg_i,
  output logic          job_valid_o,
  output ccp_pkg::job_t job_o
);

  typedef enum logic [6:0] {
    ModeIdle      = 7'b0000001,
    ModeRxName    = 7'b0000010,
    ModeAnsSelf   = 7'b0000100,
    ModeAnsMaster = 7'b0001000,
    ModeAnsType   = 7'b0010000,
    ModeAnsName   = 7'b0100000,
    ModeService   = 7'b1000000
  } mode_e;

  localparam logic [1:0] RoleNone   = 2'd0;
  localparam logic [1:0] RoleSelf   = 2'd1;
  localparam logic [1:0] RoleMaster = 2'd2;

  mode_e       mode_q, mode_d, mode_mid;
  logic [3:0]  name_cnt_q, name_cnt_d, cnt_inc;
  logic [1:0]  role_q, role_d;
  logic        tick_q, tick_d;
  logic [63:0] name_q, name_d, name_nxt;
  logic        has, ans_mode;
  logic [7:0]  c;
  ccp_pkg::job_t job;

  assign has = item_i.kind;
  assign c   = item_i.rx_byte;
  assign cnt_inc = name_cnt_q + 4'd1;
  assign ans_mode = (mode_q == ModeAnsSelf) || (mode_q == ModeAnsMaster) ||
                    (mode_q == ModeAnsType) || (mode_q == ModeAnsName);

  // Name buffer with the received byte written at the current position.
  always_comb begin
    name_nxt = name_q;
    for (int b = 0; b < ccp_pkg::NameDepth; b++) begin
      if (name_cnt_q[2:0] == 3'(b)) begin
        name_nxt[8*b +: 8] = c;
      end
    end
  end

  // Classify one poll and compute the next mode.
  always_comb begin
    mode_d     = mode_q;
    mode_mid   = mode_q;
    name_cnt_d = name_cnt_q;
    role_d     = role_q;
    tick_d     = tick_q | item_i.tick;
    name_d     = name_q;
    job          = '0;
    job.ans_act  = ccp_pkg::ActEcho;
    job.cmd      = ccp_pkg::CmdNone;
    if (ans_mode && !item_i.path_free) begin
      // Relay busy: the byte is refused and must come again.
      job.held = has;
    end else begin
      // Pending answer goes out first.
      unique case (mode_q)
        ModeAnsSelf: begin
          job.ans_vld = 1'b1;
          role_d      = RoleSelf;
          mode_mid    = ModeService;
        end
        ModeAnsMaster: begin
          job.ans_vld = 1'b1;
          role_d      = RoleMaster;
          mode_mid    = ModeIdle;
        end
        ModeAnsType: begin
          job.ans_vld = 1'b1;
          job.ans_act = ccp_pkg::ActTypeList;
          mode_mid    = ModeIdle;
        end
        ModeAnsName: begin
          job.ans_vld = 1'b1;
          job.ans_act = ccp_pkg::ActNameList;
          mode_mid    = ModeIdle;
        end
        default: begin
        end
      endcase
      // Periodic packet on the chain head.
      if ((mode_mid == ModeIdle) && cfg_i.is_chain_head && tick_d) begin
        job.pkt = !cfg_i.test_mode;
        tick_d  = 1'b0;
      end
      mode_d = mode_mid;
      // Command byte handling.
      if (has && !cfg_i.test_mode) begin
        unique case (mode_mid)
          ModeIdle: begin
            if (c == ccp_pkg::ByteListen) begin
              mode_d     = ModeRxName;
              name_cnt_d = 4'd0;
            end else if (c == ccp_pkg::ByteUnlisten) begin
              job.cmd = ccp_pkg::CmdUnlisten;
            end else if (c == ccp_pkg::ByteService) begin
              job.cmd_byte = c;
              if (cfg_i.is_chain_head || (role_d == RoleSelf)) begin
                job.cmd = ccp_pkg::CmdService;
                mode_d  = ModeService;
              end else begin
                job.cmd = ccp_pkg::CmdForward;
              end
            end else if (c == ccp_pkg::ByteAirCal) begin
              job.cmd      = ccp_pkg::CmdAirCal;
              job.cmd_byte = c;
            end else if ((c == ccp_pkg::ByteNameList) || (c == ccp_pkg::ByteTypeList)) begin
              if (cfg_i.is_chain_head || cfg_i.behind_master) begin
                mode_d = (c == ccp_pkg::ByteTypeList) ? ModeAnsType : ModeAnsName;
              end else begin
                job.cmd      = ccp_pkg::CmdForward;
                job.cmd_byte = c;
              end
            end else begin
              job.cmd      = ccp_pkg::CmdForward;
              job.cmd_byte = c;
            end
          end
          ModeRxName: begin
            name_d = name_nxt;
            if (cnt_inc < 4'(ccp_pkg::NameLen)) begin
              name_cnt_d = cnt_inc;
            end else begin
              name_cnt_d = 4'd0;
              if ((name_nxt & ccp_pkg::NameMask) ==
                  (cfg_i.own_name & ccp_pkg::NameMask)) begin
                mode_d = ModeAnsSelf;
              end else if (cfg_i.behind_master) begin
                mode_d = ((name_nxt & ccp_pkg::NameMask) ==
                          (cfg_i.master_name & ccp_pkg::NameMask)) ? ModeAnsMaster
                                                                   : ModeIdle;
              end else begin
                job.cmd  = ccp_pkg::CmdNameDump;
                job.name = name_nxt;
                mode_d   = ModeIdle;
              end
            end
          end
          ModeService: begin
            if (c == ccp_pkg::ByteUnlisten) begin
              job.cmd = ccp_pkg::CmdUnlisten;
              mode_d  = ModeIdle;
            end else begin
              job.cmd      = ccp_pkg::CmdService;
              job.cmd_byte = c;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign job_o = job;
  assign job_valid_o = accept_i &&
                       (job.held || job.ans_vld || job.pkt || (job.cmd != ccp_pkg::CmdNone));

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      name_cnt_q <= 4'd0;
      role_q     <= RoleNone;
      tick_q     <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      name_cnt_q <= name_cnt_d;
      role_q     <= role_d;
      tick_q     <= tick_d;
    end
  end

  // Name buffer holds no reset value; every compared byte is written first.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      name_q <= name_d;
    end
  end

endmodule

// ===== src/ccp_queue.sv =====
module ccp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccp_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ccp_pkg::job_t data_o
);

  localparam int unsigned PtrW = (ccp_pkg::QDepth > 1) ? $clog2(ccp_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(ccp_pkg::QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(ccp_pkg::QDepth - 1);

  ccp_pkg::job_t   mem_q [ccp_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(ccp_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/ccp_back.sv =====
module ccp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  ccp_pkg::job_t       job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ccp_pkg::out_t       out_o,
  output ccp_pkg::back_stat_t stat_o
);

  // Number of results one job gives.
  function automatic logic [3:0] job_count(ccp_pkg::job_t j);
    logic [3:0] n;
    n = {3'b0, j.ans_vld} + {3'b0, j.pkt};
    unique case (j.cmd)
      ccp_pkg::CmdUnlisten, ccp_pkg::CmdService, ccp_pkg::CmdForward: n = n + 4'd1;
      ccp_pkg::CmdAirCal:   n = n + 4'd2;
      ccp_pkg::CmdNameDump: n = n + 4'(ccp_pkg::NameLen + 1);
      default: n = n;
    endcase
    if (j.held) begin
      n = 4'd1;
    end
    return n;
  endfunction

  // Result at position idx of a job, without the last flag.
  function automatic ccp_pkg::out_t job_result(ccp_pkg::job_t j, logic [3:0] idx);
    ccp_pkg::out_t r;
    logic [3:0]    k;
    logic [3:0]    km;
    r = '0;
    r.action = ccp_pkg::ActForward;
    k  = idx - {3'b0, j.ans_vld} - {3'b0, j.pkt};
    km = k - 4'd1;
    if (j.held) begin
      r.action = ccp_pkg::ActHeld;
    end else if (j.ans_vld && (idx == 4'd0)) begin
      r.action = j.ans_act;
    end else if (j.pkt && (idx == {3'b0, j.ans_vld})) begin
      r.action = ccp_pkg::ActPacket;
    end else begin
      unique case (j.cmd)
        ccp_pkg::CmdUnlisten: r.action = ccp_pkg::ActUnlisten;
        ccp_pkg::CmdService: begin
          r.action   = ccp_pkg::ActService;
          r.out_byte = j.cmd_byte;
        end
        ccp_pkg::CmdAirCal: begin
          if (k == 4'd0) begin
            r.action = ccp_pkg::ActAirCal;
          end else begin
            r.action   = ccp_pkg::ActForward;
            r.out_byte = j.cmd_byte;
          end
        end
        ccp_pkg::CmdNameDump: begin
          r.action = ccp_pkg::ActForward;
          if (k == 4'd0) begin
            r.out_byte = ccp_pkg::ByteListen;
          end else begin
            r.out_byte = 8'(j.name >> {km[2:0], 3'b000});
          end
        end
        default: begin
          r.action   = ccp_pkg::ActForward;
          r.out_byte = j.cmd_byte;
        end
      endcase
    end
    return r;
  endfunction

  ccp_pkg::job_t job_q;
  logic          job_vld_q, job_vld_d;
  logic [3:0]    idx_q, idx_d;
  ccp_pkg::out_t out_q, res;
  logic          out_vld_q, out_vld_d;
  logic          can_out, emit, is_last, load;

  assign can_out = !out_vld_q || pop_i;
  assign emit    = job_vld_q && can_out;
  assign is_last = (idx_q == job_count(job_q) - 4'd1);
  assign load    = !job_vld_q || (emit && is_last);
  assign job_pop_o = load && job_valid_i;

  always_comb begin
    res      = job_result(job_q, idx_q);
    res.last = is_last;
  end

  // Sequencer: one result of the current job per beat.
  always_comb begin
    job_vld_d = job_vld_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    if (pop_i) begin
      out_vld_d = 1'b0;
    end
    if (emit) begin
      out_vld_d = 1'b1;
      idx_d     = idx_q + 4'd1;
    end
    if (load) begin
      job_vld_d = job_valid_i;
      idx_d     = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= 4'd0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;
  assign stat_o  = '{busy: job_vld_q, idx: idx_q};

endmodule

// ===== src/chain_command_parser_core.sv =====
// Command parser for a daisy-chained serial sensor link.
// Input channel: one beat per poll (kind, rx_byte, path_free, tick), taken at
// a rising edge with push high and full low. Output channel: result beats
// (action, out_byte, last), the oldest shown while empty is low and taken
// with pop. A poll gives zero to nine results; last marks the final one.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and 64-bit
// data; ready is always high. Write only while no poll is in flight.
// The front classifies a poll in the cycle it is accepted and updates the
// mode, so polls may follow each other in every cycle while full is low.
// Jobs wait in a two-entry queue; the back emits one result per cycle from
// the current job while pop is high or the output register is empty. It
// takes the next job as it emits the last result; a forwarded name gives nine.
// A poll's results pass the queue, the job register and the output register.
// When pop stays low the output register holds, the back stops, the queue
// fills and full rises. Reset clears the mode, the name count, the listen
// role, the pending tick, all configuration registers and both channels.
module chain_command_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ccp_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output ccp_pkg::out_t out_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  ccp_pkg::cfg_t       cfg_q;
  ccp_pkg::job_t       enq_job, deq_job;
  logic                enq, deq_vld, deq_pop, accept;
  ccp_pkg::back_stat_t back_stat;

  assign cfg_ready_o = 1'b1;
  assign accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ccp_pkg::CfgChainHead:  cfg_q.is_chain_head <= cfg_data_i[0];
        ccp_pkg::CfgBehindMstr: cfg_q.behind_master <= cfg_data_i[0];
        ccp_pkg::CfgTestMode:   cfg_q.test_mode     <= cfg_data_i[0];
        ccp_pkg::CfgOwnName:    cfg_q.own_name      <= cfg_data_i;
        ccp_pkg::CfgMasterName: cfg_q.master_name   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ccp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_i),
    .cfg_i       (cfg_q),
    .job_valid_o (enq),
    .job_o       (enq_job)
  );

  ccp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (enq_job),
    .full_o  (full),
    .pop_i   (deq_pop),
    .valid_o (deq_vld),
    .data_o  (deq_job)
  );

  ccp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (deq_vld),
    .job_i       (deq_job),
    .job_pop_o   (deq_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o),
    .stat_o      (back_stat)
  );

  // A full queue always offers a job to the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> deq_vld)
    else $error("job queue full but shows no job");

  // A job pushed by the front is still waiting or taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   enq |=> (deq_vld || back_stat.busy))
    else $error("job lost between front and back");

  // A held byte is always the only result of its poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && (out_o.action == ccp_pkg::ActHeld)) |-> out_o.last)
    else $error("held result not marked last");

  // The back never runs past the results of its job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   back_stat.busy |-> (back_stat.idx < 4'(ccp_pkg::NameLen + 1)))
    else $error("result index beyond job length");

endmodule

// ===== tb/ccp_tb_pkg.sv =====
package ccp_tb_pkg;

  import ccp_pkg::*;

  // Command mode as the scoreboard tracks it.
  typedef enum logic [2:0] {
    ModeIdle,
    ModeName,
    ModeAnsSelf,
    ModeAnsMaster,
    ModeAnsType,
    ModeAnsName,
    ModeService
  } parse_mode_e;

  // Role left behind by the last answered Listen.
  localparam logic [1:0] RoleNone   = 2'd0;
  localparam logic [1:0] RoleSelf   = 2'd1;
  localparam logic [1:0] RoleMaster = 2'd2;

  // Tracks the parser state, turns each accepted poll into the result beats it must
  // cause and checks the result beats in order against them.
  class chain_scoreboard;
    logic        chain_head;
    logic        behind_master;
    logic        test_mode;
    logic [63:0] own_name;
    logic [63:0] master_name;
    parse_mode_e mode;
    logic [3:0]  name_cnt;
    logic [7:0]  name_buf [NameDepth];
    logic [1:0]  role;
    logic        tick_due;
    out_t        poll_beats [$];
    out_t        due_beats [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned polls;

    function new();
      chain_head    = 1'b0;
      behind_master = 1'b0;
      test_mode     = 1'b0;
      own_name      = '0;
      master_name   = '0;
      mode          = ModeIdle;
      name_cnt      = '0;
      role          = RoleNone;
      tick_due      = 1'b0;
      errors        = 0;
      checked       = 0;
      polls         = 0;
      foreach (name_buf[i]) name_buf[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        CfgChainHead:  chain_head = val[0];
        CfgBehindMstr: behind_master = val[0];
        CfgTestMode:   test_mode = val[0];
        CfgOwnName:    own_name = val;
        CfgMasterName: master_name = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_beats.size();
    endfunction

    function void put(action_e act, logic [7:0] val);
      out_t b;
      b.action   = act;
      b.out_byte = val;
      b.last     = 1'b0;
      poll_beats.push_back(b);
    endfunction

    // Compares the collected name with the first NameLen bytes of nm.
    function logic name_is(logic [63:0] nm);
      for (int i = 0; i < NameLen; i++) begin
        if (name_buf[i] !== nm[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Accepted poll: advance the state and queue the result beats it causes.
    function void note_poll(in_t p);
      logic stop;
      stop = 1'b0;
      poll_beats.delete();
      polls++;
      if (p.tick) tick_due = 1'b1;

      // A pending answer goes out first, unless the relay is busy.
      if (mode == ModeAnsSelf || mode == ModeAnsMaster ||
          mode == ModeAnsType || mode == ModeAnsName) begin
        if (!p.path_free) begin
          if (p.kind) put(ActHeld, 8'h00);
          stop = 1'b1;
        end else begin
          case (mode)
            ModeAnsSelf: begin
              role = RoleSelf;
              put(ActEcho, 8'h00);
              mode = ModeService;
            end
            ModeAnsMaster: begin
              role = RoleMaster;
              put(ActEcho, 8'h00);
              mode = ModeIdle;
            end
            ModeAnsType: begin
              put(ActTypeList, 8'h00);
              mode = ModeIdle;
            end
            default: begin
              put(ActNameList, 8'h00);
              mode = ModeIdle;
            end
          endcase
        end
      end

      // The chain head sends its periodic packet when idle.
      if (!stop && mode == ModeIdle && chain_head && tick_due) begin
        if (!test_mode) put(ActPacket, 8'h00);
        tick_due = 1'b0;
      end

      // Command byte handling; test mode drops the byte.
      if (!stop && p.kind && !test_mode) begin
        case (mode)
          ModeIdle: begin
            if (p.rx_byte == ByteListen) begin
              mode     = ModeName;
              name_cnt = '0;
            end else if (p.rx_byte == ByteUnlisten) begin
              put(ActUnlisten, 8'h00);
            end else if (p.rx_byte == ByteService) begin
              if (chain_head || role == RoleSelf) begin
                put(ActService, p.rx_byte);
                mode = ModeService;
              end else begin
                put(ActForward, p.rx_byte);
              end
            end else if (p.rx_byte == ByteAirCal) begin
              put(ActAirCal, 8'h00);
              put(ActForward, p.rx_byte);
            end else if (p.rx_byte == ByteNameList || p.rx_byte == ByteTypeList) begin
              if (chain_head || behind_master) begin
                mode = (p.rx_byte == ByteTypeList) ? ModeAnsType : ModeAnsName;
              end else begin
                put(ActForward, p.rx_byte);
              end
            end else begin
              put(ActForward, p.rx_byte);
            end
          end
          ModeName: begin
            name_buf[name_cnt[2:0]] = p.rx_byte;
            name_cnt = name_cnt + 4'd1;
            if (name_cnt >= NameLen) begin
              name_cnt = '0;
              if (name_is(own_name)) begin
                mode = ModeAnsSelf;
              end else if (behind_master) begin
                // A name that is not the master's is dropped behind the master.
                mode = name_is(master_name) ? ModeAnsMaster : ModeIdle;
              end else begin
                put(ActForward, ByteListen);
                for (int i = 0; i < NameLen; i++) put(ActForward, name_buf[i]);
                mode = ModeIdle;
              end
            end
          end
          ModeService: begin
            if (p.rx_byte == ByteUnlisten) begin
              put(ActUnlisten, 8'h00);
              mode = ModeIdle;
            end else begin
              put(ActService, p.rx_byte);
            end
          end
          default: ;
        endcase
      end

      if (poll_beats.size() > 0) poll_beats[poll_beats.size() - 1].last = 1'b1;
      foreach (poll_beats[i]) due_beats.push_back(poll_beats[i]);
    endfunction

    // Accepted result beat: compare it with the oldest expected beat.
    function void check_result(out_t got);
      out_t want;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result beat: action %0d byte %02h last %0b",
                   got.action, got.out_byte, got.last);
        end
        return;
      end
      want = due_beats.pop_front();
      checked++;
      if (got.action !== want.action || got.out_byte !== want.out_byte ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("Result beat %0d: expected action %0d byte %02h last %0b,",
                   checked, want.action, want.out_byte, want.last,
                   " got action %0d byte %02h last %0b",
                   got.action, got.out_byte, got.last);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_chain_command_parser_core.sv =====
module tb_chain_command_parser_core;

  import ccp_pkg::*;
  import ccp_tb_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseItems   = 76;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_t         poll = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CfgChainHead;
  logic [63:0] cfg_data = '0;

  chain_scoreboard sb;
  int unsigned     cycles = 0;
  int unsigned     settings = 0;
  logic            calm_tx = 1'b0;
  logic            calm_rx = 1'b0;

  chain_command_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (poll),
    .empty       (empty),
    .pop         (pop),
    .out_o       (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d result beats outstanding.",
               cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic in_t poll_of(input logic k, input logic [7:0] rb,
                                  input logic ri, input logic tk);
    in_t p;
    p.kind      = k;
    p.rx_byte   = rb;
    p.path_free = ri;
    p.tick      = tk;
    return p;
  endfunction

  // Poll with the given kind and byte and random relay and tick flags.
  function automatic in_t rand_poll(input logic k, input logic [7:0] rb);
    return poll_of(k, rb, $urandom_range(3) != 0, $urandom_range(4) == 0);
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] nm;
    for (int i = 0; i < 8; i++) nm[8*i +: 8] = 8'($urandom_range(8'h7e, 8'h20));
    return nm;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Name for a Listen: own, master, own with one byte spoiled, or noise.
  function automatic logic [63:0] pick_name();
    logic [63:0] nm;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(NameLen - 1);
    if (r < 40) begin
      nm = sb.own_name;
    end else if (r < 65) begin
      nm = sb.master_name;
    end else if (r < 82) begin
      nm = sb.own_name;
      nm[8*k +: 8] = ~nm[8*k +: 8];
    end else begin
      nm = rand_word();
    end
    return nm;
  endfunction

  // Random command byte, biased toward the bytes the parser decodes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(14))
      0: return ByteListen;
      1: return ByteUnlisten;
      2: return ByteNameList;
      3: return ByteTypeList;
      4: return ByteService;
      5: return ByteAirCal;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Present one poll beat and wait until it is taken.
  task automatic send_poll(input in_t p);
    int unsigned gap;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    poll <= p;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_poll(p);
    if (sb.polls % 32 == 0) calm_tx = ($urandom_range(3) == 0);
  endtask

  // Stop sending until every expected beat has come, then let the back settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Write all five registers; flag registers get random upper bits.
  task automatic apply_config(input logic ch, input logic bm, input logic tm,
                              input logic [63:0] own, input logic [63:0] mst);
    logic [63:0] junk;
    junk = rand_word();
    write_reg(CfgChainHead, {junk[63:1], ch});
    write_reg(CfgBehindMstr, {junk[62:0], bm});
    write_reg(CfgTestMode, {junk[63:1], tm});
    write_reg(CfgOwnName, own);
    write_reg(CfgMasterName, mst);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Mix of complete Listen sequences, single commands, noise and rare drains.
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned r;
    logic [63:0] nm;
    stop_at = sb.polls + count;
    while (sb.polls < stop_at) begin
      r = $urandom_range(99);
      if (r < 25) begin
        nm = pick_name();
        send_poll(rand_poll(1'b1, ByteListen));
        for (int i = 0; i < NameLen; i++) send_poll(rand_poll(1'b1, nm[8*i +: 8]));
      end else if (r < 27) begin
        drain();
      end else begin
        send_poll(rand_poll($urandom_range(99) < 85, pick_byte()));
      end
    end
  endtask

  // Result side: pop with random stalls and calm stretches.
  initial begin
    int unsigned stall;
    int unsigned span;
    stall = 0;
    span  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(result);
      if (span == 0) begin
        span    = 64;
        calm_rx = ($urandom_range(3) == 0);
      end
      span--;
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap(calm_rx);
      end
    end
  end

  // Stimulus.
  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a chain head.
    apply_config(1'b1, 1'b0, 1'b0, rand_name(), rand_name());
    send_poll(poll_of(1'b0, 8'h00, 1'b1, 1'b1));
    send_poll(poll_of(1'b1, ByteAirCal, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, 8'h00, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, 8'hFF, 1'b1, 1'b1));
    // Type list answer, held back while the relay is busy.
    send_poll(poll_of(1'b1, ByteTypeList, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, 8'h41, 1'b0, 1'b0));
    send_poll(poll_of(1'b0, 8'h41, 1'b0, 1'b0));
    send_poll(poll_of(1'b0, 8'h00, 1'b1, 1'b0));
    // Name list answer followed by a forwarded byte in the same poll.
    send_poll(poll_of(1'b1, ByteNameList, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, 8'h12, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, ByteUnlisten, 1'b1, 1'b0));
    // Listen with the own name, then service mode and back out.
    send_poll(poll_of(1'b1, ByteListen, 1'b1, 1'b0));
    for (int i = 0; i < NameLen; i++) begin
      send_poll(poll_of(1'b1, sb.own_name[8*i +: 8], 1'b0, 1'b0));
    end
    send_poll(poll_of(1'b0, 8'h00, 1'b1, 1'b1));
    send_poll(poll_of(1'b1, 8'h5A, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, ByteUnlisten, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, ByteService, 1'b1, 1'b0));
    send_poll(poll_of(1'b1, ByteUnlisten, 1'b1, 1'b0));

    // Random phases over several register settings.
    drain();
    apply_config(1'b0, 1'b0, 1'b0, rand_name(), rand_name());
    run_random(PhaseItems);
    drain();
    apply_config(1'b0, 1'b1, 1'b0, rand_name(), rand_name());
    run_random(PhaseItems);
    drain();
    apply_config(1'b1, 1'b1, 1'b1, '1, '0);
    run_random(PhaseItems);
    drain();
    apply_config(1'b1, 1'b0, 1'b0, '0, '1);
    run_random(PhaseItems);
    drain();
    apply_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 rand_word(), rand_word());
    run_random(PhaseItems);
    drain();
    apply_config(1'b0, 1'b1, 1'b0, rand_word(), rand_name());
    run_random(PhaseItems);
    drain();

    $display("Sent %0d polls under %0d register settings;", sb.polls, settings,
             " %0d result beats checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
